/* rtl/core/t2c_pkg.sv */
// Shared constants for the 2D transform compose core.
package t2c_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;

  // Start-to-strobe pipeline depth in register stages.
  localparam int PIPE_DEPTH = 8;

  localparam int FRAC_BITS  = 16;
  localparam int PHASE_BITS = 16;

  // Quarter-wave sine polynomial, Q14 in, Q15 out.
  localparam logic [15:0] SIN_A       = 16'd51472;
  localparam logic [15:0] SIN_B       = 16'd21024;
  localparam logic [15:0] SIN_C       = 16'd2320;
  localparam logic [14:0] QUARTER     = 15'd16384;
  localparam logic [15:0] SIN_ONE     = 16'd32768;
  localparam logic [13:0] Q14_HALF    = 14'd8192;

endpackage

/* rtl/core/transform_2d_compose_core.sv */
// Top level: pipelined composition of a child 2D transform with its parent.
//
// Usage
//   Input channel: a word (parent and child transform, inherit flags) is
//   taken at each rising edge where start is high and busy is low. busy
//   stays low: the pipeline advances every cycle and takes one word per
//   cycle, back to back.
//   Result channel: out_valid is high for exactly one cycle per word, with
//   the composed transform on the out_ ports. The receiver cannot stall;
//   results are never held, so no backpressure path exists.
//   Order: results leave in the order in which the words were taken.
//   Throughput: 1 word per cycle. The sine/cosine polynomial is the longest
//   chain (four dependent multiplies, one stage each), followed by the
//   rotation product and its sum; the parent scale product is split into
//   half-width partial products summed one stage later.
//   Reset: synchronous, active low; clears all stage valid bits, so words in
//   flight are dropped and no strobe follows.
module transform_2d_compose_core #(
  parameter int COORD_WIDTH = t2c_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = t2c_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_parent_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_parent_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_parent_scale_x,
  input  logic signed [COORD_WIDTH-1:0] in_parent_scale_y,
  input  logic        [ANGLE_WIDTH-1:0] in_parent_angle,
  input  logic signed [COORD_WIDTH-1:0] in_child_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_child_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_child_scale_x,
  input  logic signed [COORD_WIDTH-1:0] in_child_scale_y,
  input  logic        [ANGLE_WIDTH-1:0] in_child_angle,
  input  logic signed [COORD_WIDTH-1:0] in_child_depth,
  input  logic        [2:0]             in_inherit_flags,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH-1:0] out_scale_x,
  output logic signed [COORD_WIDTH-1:0] out_scale_y,
  output logic        [ANGLE_WIDTH-1:0] out_angle,
  output logic signed [COORD_WIDTH-1:0] out_depth,
  output logic        [2:0]             out_flags
);

  localparam int W     = COORD_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int ND    = t2c_pkg::PIPE_DEPTH;
  localparam int LO_W  = W / 2;
  localparam int HI_W  = W - LO_W;
  localparam int PW    = 2 * W;
  localparam int MAG_W = PW - t2c_pkg::FRAC_BITS;
  localparam int RP_W  = W + 17;
  localparam int RS_W  = W + 18;
  localparam int RT_W  = W + 3;

  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_coord(input logic signed [RT_W-1:0] v);
    logic [RT_W-W:0] top;
    top = v[RT_W-1:W-1];
    if ((&top) || !(|top)) begin
      return v[W-1:0];
    end
    return v[RT_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  assign busy = 1'b0;

  logic [ND-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ND-2:0], start & ~busy};
    end
  end

  // Pass-through fields, one register per stage.
  logic signed [W-1:0]  ppx_r   [0:6];
  logic signed [W-1:0]  ppy_r   [0:6];
  logic        [AW-1:0] pang_r  [0:6];
  logic        [AW-1:0] cang_r  [0:6];
  logic signed [W-1:0]  csx_r   [0:6];
  logic signed [W-1:0]  csy_r   [0:6];
  logic signed [W-1:0]  depth_r [0:6];
  logic        [2:0]    flags_r [0:6];
  logic signed [W-1:0]  cpx_r   [0:4];
  logic signed [W-1:0]  cpy_r   [0:4];

  always_ff @(posedge clk) begin
    ppx_r[0]   <= in_parent_pos_x;
    ppy_r[0]   <= in_parent_pos_y;
    pang_r[0]  <= in_parent_angle;
    cang_r[0]  <= in_child_angle;
    csx_r[0]   <= in_child_scale_x;
    csy_r[0]   <= in_child_scale_y;
    depth_r[0] <= in_child_depth;
    flags_r[0] <= in_inherit_flags;
    cpx_r[0]   <= in_child_pos_x;
    cpy_r[0]   <= in_child_pos_y;
    for (int i = 1; i < 7; i++) begin
      ppx_r[i]   <= ppx_r[i-1];
      ppy_r[i]   <= ppy_r[i-1];
      pang_r[i]  <= pang_r[i-1];
      cang_r[i]  <= cang_r[i-1];
      csx_r[i]   <= csx_r[i-1];
      csy_r[i]   <= csy_r[i-1];
      depth_r[i] <= depth_r[i-1];
      flags_r[i] <= flags_r[i-1];
    end
    for (int i = 1; i < 5; i++) begin
      cpx_r[i] <= cpx_r[i-1];
      cpy_r[i] <= cpy_r[i-1];
    end
  end

  // Stage 0: phase, quadrant fold, scale magnitudes.
  logic [AW+15:0] pang_ext;
  logic [15:0]    sph, cph;
  logic [14:0]    sx_nxt, cx_nxt;
  logic [W-1:0]   amx_nxt, bmx_nxt, amy_nxt, bmy_nxt;

  always_comb begin
    pang_ext = {in_parent_angle, 16'b0};
    sph      = pang_ext[AW+15:AW];
    cph      = sph + {2'b01, 14'b0};
    sx_nxt   = sph[14] ? 15'(t2c_pkg::QUARTER - 15'(sph[13:0])) : 15'(sph[13:0]);
    cx_nxt   = cph[14] ? 15'(t2c_pkg::QUARTER - 15'(cph[13:0])) : 15'(cph[13:0]);
    amx_nxt  = in_child_scale_x[W-1]  ? W'(-in_child_scale_x)  : in_child_scale_x;
    bmx_nxt  = in_parent_scale_x[W-1] ? W'(-in_parent_scale_x) : in_parent_scale_x;
    amy_nxt  = in_child_scale_y[W-1]  ? W'(-in_child_scale_y)  : in_child_scale_y;
    bmy_nxt  = in_parent_scale_y[W-1] ? W'(-in_parent_scale_y) : in_parent_scale_y;
  end

  logic [14:0]  sx_r [0:3];
  logic [14:0]  cx_r [0:3];
  logic         sneg_r [0:3];
  logic         cneg_r [0:3];
  logic [W-1:0] amx_r, bmx_r, amy_r, bmy_r;
  logic         negx_r [0:2];
  logic         negy_r [0:2];

  always_ff @(posedge clk) begin
    sx_r[0]   <= sx_nxt;
    cx_r[0]   <= cx_nxt;
    sneg_r[0] <= sph[15];
    cneg_r[0] <= cph[15];
    amx_r     <= amx_nxt;
    bmx_r     <= bmx_nxt;
    amy_r     <= amy_nxt;
    bmy_r     <= bmy_nxt;
    negx_r[0] <= in_child_scale_x[W-1] ^ in_parent_scale_x[W-1];
    negy_r[0] <= in_child_scale_y[W-1] ^ in_parent_scale_y[W-1];
    for (int i = 1; i < 4; i++) begin
      sx_r[i]   <= sx_r[i-1];
      cx_r[i]   <= cx_r[i-1];
      sneg_r[i] <= sneg_r[i-1];
      cneg_r[i] <= cneg_r[i-1];
    end
    for (int i = 1; i < 3; i++) begin
      negx_r[i] <= negx_r[i-1];
      negy_r[i] <= negy_r[i-1];
    end
  end

  // Stage 1: x^2, scale partial products.
  logic [29:0]         sq_s, sq_c;
  logic [14:0]         sx2_nxt, cx2_nxt;
  logic [2*LO_W-1:0]   xll_nxt, yll_nxt;
  logic [W-1:0]        xlh_nxt, xhl_nxt, ylh_nxt, yhl_nxt;
  logic [2*HI_W-1:0]   xhh_nxt, yhh_nxt;

  always_comb begin
    sq_s    = 30'(sx_r[0]) * 30'(sx_r[0]) + 30'(t2c_pkg::Q14_HALF);
    sq_c    = 30'(cx_r[0]) * 30'(cx_r[0]) + 30'(t2c_pkg::Q14_HALF);
    sx2_nxt = sq_s[28:14];
    cx2_nxt = sq_c[28:14];
    xll_nxt = (2*LO_W)'(amx_r[LO_W-1:0]) * (2*LO_W)'(bmx_r[LO_W-1:0]);
    xlh_nxt = W'(amx_r[LO_W-1:0]) * W'(bmx_r[W-1:LO_W]);
    xhl_nxt = W'(amx_r[W-1:LO_W]) * W'(bmx_r[LO_W-1:0]);
    xhh_nxt = (2*HI_W)'(amx_r[W-1:LO_W]) * (2*HI_W)'(bmx_r[W-1:LO_W]);
    yll_nxt = (2*LO_W)'(amy_r[LO_W-1:0]) * (2*LO_W)'(bmy_r[LO_W-1:0]);
    ylh_nxt = W'(amy_r[LO_W-1:0]) * W'(bmy_r[W-1:LO_W]);
    yhl_nxt = W'(amy_r[W-1:LO_W]) * W'(bmy_r[LO_W-1:0]);
    yhh_nxt = (2*HI_W)'(amy_r[W-1:LO_W]) * (2*HI_W)'(bmy_r[W-1:LO_W]);
  end

  logic [14:0]       sx2_r [1:2];
  logic [14:0]       cx2_r [1:2];
  logic [2*LO_W-1:0] xll_r, yll_r;
  logic [W-1:0]      xlh_r, xhl_r, ylh_r, yhl_r;
  logic [2*HI_W-1:0] xhh_r, yhh_r;

  always_ff @(posedge clk) begin
    sx2_r[1] <= sx2_nxt;
    cx2_r[1] <= cx2_nxt;
    sx2_r[2] <= sx2_r[1];
    cx2_r[2] <= cx2_r[1];
    xll_r    <= xll_nxt;
    xlh_r    <= xlh_nxt;
    xhl_r    <= xhl_nxt;
    xhh_r    <= xhh_nxt;
    yll_r    <= yll_nxt;
    ylh_r    <= ylh_nxt;
    yhl_r    <= yhl_nxt;
    yhh_r    <= yhh_nxt;
  end

  // Stage 2: t = B - C*x2, scale product sum with rounding bias.
  logic [26:0] ct_s, ct_c;
  logic [14:0] st_nxt, ctn_nxt;
  logic [PW-1:0] prx_nxt, pry_nxt;

  always_comb begin
    ct_s    = 27'(t2c_pkg::SIN_C) * 27'(sx2_r[1]) + 27'(t2c_pkg::Q14_HALF);
    ct_c    = 27'(t2c_pkg::SIN_C) * 27'(cx2_r[1]) + 27'(t2c_pkg::Q14_HALF);
    st_nxt  = 15'(27'(t2c_pkg::SIN_B) - (ct_s >> 14));
    ctn_nxt = 15'(27'(t2c_pkg::SIN_B) - (ct_c >> 14));
    prx_nxt = (PW'(xhh_r) << (2*LO_W)) + ((PW'(xlh_r) + PW'(xhl_r)) << LO_W)
            + PW'(xll_r) + (PW'(1) << (t2c_pkg::FRAC_BITS - 1));
    pry_nxt = (PW'(yhh_r) << (2*LO_W)) + ((PW'(ylh_r) + PW'(yhl_r)) << LO_W)
            + PW'(yll_r) + (PW'(1) << (t2c_pkg::FRAC_BITS - 1));
  end

  logic [14:0]   st_r, ct_r;
  logic [PW-1:0] prx_r, pry_r;

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    ct_r  <= ctn_nxt;
    prx_r <= prx_nxt;
    pry_r <= pry_nxt;
  end

  // Stage 3: t2 = A - t*x2, scale clamp and sign.
  logic [29:0]         tt_s, tt_c;
  logic [15:0]         st2_nxt, ct2_nxt;
  logic [MAG_W-1:0]    magx, magy, limx, limy;
  logic signed [W-1:0] sclx_nxt, scly_nxt;

  always_comb begin
    tt_s    = 30'(st_r) * 30'(sx2_r[2]) + 30'(t2c_pkg::Q14_HALF);
    tt_c    = 30'(ct_r) * 30'(cx2_r[2]) + 30'(t2c_pkg::Q14_HALF);
    st2_nxt = 16'(30'(t2c_pkg::SIN_A) - (tt_s >> 14));
    ct2_nxt = 16'(30'(t2c_pkg::SIN_A) - (tt_c >> 14));
    limx    = negx_r[2] ? (MAG_W'(1) << (W-1)) : ((MAG_W'(1) << (W-1)) - MAG_W'(1));
    limy    = negy_r[2] ? (MAG_W'(1) << (W-1)) : ((MAG_W'(1) << (W-1)) - MAG_W'(1));
    magx    = prx_r[PW-1:t2c_pkg::FRAC_BITS];
    magy    = pry_r[PW-1:t2c_pkg::FRAC_BITS];
    if (magx > limx) begin
      magx = limx;
    end
    if (magy > limy) begin
      magy = limy;
    end
    sclx_nxt = negx_r[2] ? -W'(magx) : W'(magx);
    scly_nxt = negy_r[2] ? -W'(magy) : W'(magy);
  end

  logic [15:0]         st2_r, ct2_r;
  logic signed [W-1:0] sclx_r [3:6];
  logic signed [W-1:0] scly_r [3:6];

  always_ff @(posedge clk) begin
    st2_r     <= st2_nxt;
    ct2_r     <= ct2_nxt;
    sclx_r[3] <= sclx_nxt;
    scly_r[3] <= scly_nxt;
    for (int i = 4; i < 7; i++) begin
      sclx_r[i] <= sclx_r[i-1];
      scly_r[i] <= scly_r[i-1];
    end
  end

  // Stage 4: final sine product, clamp, quadrant sign.
  logic [30:0]        fs, fc;
  logic [15:0]        smag, cmag;
  logic signed [16:0] sin_nxt, cos_nxt;

  always_comb begin
    fs   = 31'(st2_r) * 31'(sx_r[3]) + 31'(t2c_pkg::Q14_HALF);
    fc   = 31'(ct2_r) * 31'(cx_r[3]) + 31'(t2c_pkg::Q14_HALF);
    smag = fs[29:14];
    cmag = fc[29:14];
    if (smag > t2c_pkg::SIN_ONE) begin
      smag = t2c_pkg::SIN_ONE;
    end
    if (cmag > t2c_pkg::SIN_ONE) begin
      cmag = t2c_pkg::SIN_ONE;
    end
    sin_nxt = sneg_r[3] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    cos_nxt = cneg_r[3] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  end

  logic signed [16:0] sin_r, cos_r;

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  // Stage 5: rotation products.
  logic signed [RP_W-1:0] mxc_r, mys_r, mxs_r, myc_r;

  always_ff @(posedge clk) begin
    mxc_r <= RP_W'(cpx_r[4]) * RP_W'(cos_r);
    mys_r <= RP_W'(cpy_r[4]) * RP_W'(sin_r);
    mxs_r <= RP_W'(cpx_r[4]) * RP_W'(sin_r);
    myc_r <= RP_W'(cpy_r[4]) * RP_W'(cos_r);
  end

  // Stage 6: rotation sums, round, saturate.
  logic signed [RS_W-1:0] rsx, rsy;
  logic signed [W-1:0]    rpx_nxt, rpy_nxt;

  always_comb begin
    rsx     = RS_W'(mxc_r) - RS_W'(mys_r) + RS_W'(16384);
    rsy     = RS_W'(mxs_r) + RS_W'(myc_r) + RS_W'(16384);
    rpx_nxt = sat_coord(rsx[RS_W-1:15]);
    rpy_nxt = sat_coord(rsy[RS_W-1:15]);
  end

  logic signed [W-1:0] rpx_r, rpy_r;

  always_ff @(posedge clk) begin
    rpx_r <= rpx_nxt;
    rpy_r <= rpy_nxt;
  end

  // Stage 7: inherit selection into the output registers.
  logic signed [RT_W-1:0] apx, apy;
  logic signed [W-1:0]    px_nxt, py_nxt, sx_o_nxt, sy_o_nxt;
  logic [AW-1:0]          ang_nxt;

  always_comb begin
    apx      = RT_W'(rpx_r) + RT_W'(ppx_r[6]);
    apy      = RT_W'(rpy_r) + RT_W'(ppy_r[6]);
    px_nxt   = flags_r[6][0] ? sat_coord(apx) : rpx_r;
    py_nxt   = flags_r[6][0] ? sat_coord(apy) : rpy_r;
    sx_o_nxt = flags_r[6][1] ? sclx_r[6] : csx_r[6];
    sy_o_nxt = flags_r[6][1] ? scly_r[6] : csy_r[6];
    ang_nxt  = flags_r[6][2] ? AW'(cang_r[6] + pang_r[6]) : cang_r[6];
  end

  logic signed [W-1:0] px_r, py_r, sxo_r, syo_r, dep_r;
  logic [AW-1:0]       ang_r;
  logic [2:0]          flg_r;

  always_ff @(posedge clk) begin
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    sxo_r <= sx_o_nxt;
    syo_r <= sy_o_nxt;
    ang_r <= ang_nxt;
    dep_r <= depth_r[6];
    flg_r <= flags_r[6];
  end

  assign out_valid   = vld_r[ND-1];
  assign out_pos_x   = px_r;
  assign out_pos_y   = py_r;
  assign out_scale_x = sxo_r;
  assign out_scale_y = syo_r;
  assign out_angle   = ang_r;
  assign out_depth   = dep_r;
  assign out_flags   = flg_r;

endmodule

/* rtl/core/t2c_checker.sv */
// Port-level checker for the 2D transform compose core, with its bind.
module t2c_checker #(
  parameter int COORD_WIDTH = t2c_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = t2c_pkg::ANGLE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [ANGLE_WIDTH-1:0] in_child_angle,
  input logic [COORD_WIDTH-1:0] in_child_depth,
  input logic [2:0]             in_inherit_flags,
  input logic                   out_valid,
  input logic [ANGLE_WIDTH-1:0] out_angle,
  input logic [COORD_WIDTH-1:0] out_depth,
  input logic [2:0]             out_flags
);

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(t2c_pkg::PIPE_DEPTH) out_valid)
    else $error("accepted word produced no result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(t2c_pkg::PIPE_DEPTH) !out_valid)
    else $error("result strobe without an accepted word");

  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_depth == $past(in_child_depth, t2c_pkg::PIPE_DEPTH)) &&
                  (out_flags == $past(in_inherit_flags, t2c_pkg::PIPE_DEPTH)))
    else $error("depth or flags not carried through");

  a_angle_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_flags[2]) |->
      out_angle == $past(in_child_angle, t2c_pkg::PIPE_DEPTH))
    else $error("child angle changed without rotation inherit");

endmodule

bind transform_2d_compose_core t2c_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_t2c_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_child_angle  (in_child_angle),
  .in_child_depth  (in_child_depth),
  .in_inherit_flags(in_inherit_flags),
  .out_valid       (out_valid),
  .out_angle       (out_angle),
  .out_depth       (out_depth),
  .out_flags       (out_flags)
);
